// ===== src/lottery_weighted_scheduler_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Lottery weighted scheduler: assertion macros
// Shared assertion macros for the checker; clock aclk and reset aresetn are
// taken from the scope in which a macro is used.
// ----------------------------------------------------------------------------
`ifndef LOTTERY_WEIGHTED_SCHEDULER_UNIT_DEFINES_SVH
`define LOTTERY_WEIGHTED_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LWS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lws_pkg.sv =====
// ----------------------------------------------------------------------------
// Lottery weighted scheduler package
// Sequencer states, configuration and command codes and the result layout.
// ----------------------------------------------------------------------------
package lws_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_DIV,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } lws_state_t;

    // Configuration register indexes.
    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_ACTIVE = 1'b1;

    // Request kinds carried on s_tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;
    localparam int RES_W       = 26;

    // Result fields, first field in the highest bits.
    typedef struct packed {
        logic        all_retired;
        logic        just_retired;
        logic [15:0] served_count;
        logic [6:0]  chosen_index;
        logic        found;
    } lws_result_t;

endpackage

// ===== src/lottery_weighted_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Lottery weighted scheduler unit
// Weighted random selection over a table of requesters with served counts
// and retirement at a programmable target count.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Carries
//  s_        in         s_tvalid/s_tready  load or draw request
//  m_        out        m_tvalid/m_tready  draw result, one per draw
//  cfg_      in         cfg_valid/cfg_ready register index and write data
//
// A load request writes the table once. A draw makes a summing pass over the
// table memory, a bit-serial modulo reduction of the 32-bit random word, a scan up
// to the chosen entry, a read-modify-write and the output transfer. An empty draw
// makes only the summing pass and the output transfer.
// After reset a clearing pass over all ENTRIES words zeroes the table; no request is taken.
// A result waits in the output register; a draw stalls at its end only if that is full.
//
module lottery_weighted_scheduler_unit
    import lws_pkg::*;
#(
    parameter int ENTRIES     = 128,
    parameter int WEIGHT_BITS = 8,
    parameter int COUNT_BITS  = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Request channel.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // entry_index[6:0], weight_value[14:7], random_word[46:15], zero pad [47]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // cmd[0]
    input  logic                   s_tuser,
    // Result channel.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // found[0], chosen_index[7:1], served_count[23:8], just_retired[24],
    // all_retired[25], zero pad [31:26]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Configuration channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_data
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int LIM_W  = $clog2(ENTRIES + 1);
    localparam int ACT_W  = (LIM_W > 8) ? LIM_W : 8;
    localparam int SUM_W  = WEIGHT_BITS + LIM_W;
    localparam int WORD_W = 1 + COUNT_BITS + WEIGHT_BITS;

    // Table word: retired mark on top, served count, weight at the bottom.
    localparam int CNT_LSB = WEIGHT_BITS;
    localparam int MARK_B  = WORD_W - 1;

    lws_state_t state_reg, state_next;

    logic [15:0]          target_reg;
    logic [ACT_W-1:0]     active_reg;

    logic [LIM_W-1:0]     iss_reg, iss_next;
    logic                 rvalid_reg, rvalid_next;
    logic [IDX_W-1:0]     ridx_reg, ridx_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [LIM_W-1:0]     nr_reg, nr_next;
    logic [31:0]          quo_reg, quo_next;
    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [4:0]           dcnt_reg, dcnt_next;
    logic [SUM_W-1:0]     run_reg, run_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic                 ld_ok_reg, ld_ok_next;
    logic [IDX_W-1:0]     ld_addr_reg, ld_addr_next;
    logic [WEIGHT_BITS-1:0] ld_w_reg, ld_w_next;
    lws_result_t          res_reg, res_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    lws_result_t          m_tdata_reg, m_tdata_next;

    // Table memory signals.
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;

    lws_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (iss_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Fields of the word returned by the table memory.
    logic [WEIGHT_BITS-1:0] rd_w;
    logic                   rd_mark;
    assign rd_w    = ram_rdata[WEIGHT_BITS-1:0];
    assign rd_mark = ram_rdata[MARK_B];

    // Number of entries that take part in a draw: zero acts as one and
    // anything beyond the table acts as the full table.
    logic [LIM_W-1:0] n_lim;
    always_comb begin
        if (active_reg == '0) begin
            n_lim = LIM_W'(1);
        end else if (32'(active_reg) > 32'(ENTRIES)) begin
            n_lim = LIM_W'(ENTRIES);
        end else begin
            n_lim = LIM_W'(active_reg);
        end
    end

    logic accept;
    logic out_free;
    logic issue;
    logic sum_done;
    logic div_last;
    logic [SUM_W-1:0] run_new;
    logic hit;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign issue    = iss_reg < n_lim;
    assign sum_done = !issue && !rvalid_reg;
    assign div_last = dcnt_reg == 5'd31;
    assign run_new  = run_reg + SUM_W'(rd_w);
    // The reduced draw is always below the active sum, so the scan ends on
    // an entry before the active range runs out.
    assign hit      = rvalid_reg && (rem_reg < run_new);

    // Modulo step: shift in one dividend bit and subtract the sum if it fits.
    logic [SUM_W:0] div_trial;
    assign div_trial = {rem_reg, quo_reg[31]};

    // Served count update of the chosen entry.
    logic [COUNT_BITS-1:0]  upd_cnt_old;
    logic [COUNT_BITS-1:0]  upd_cnt;
    logic [15:0]            target_eff;
    logic                   upd_retire;
    logic                   upd_newly;
    assign upd_cnt_old = word_reg[CNT_LSB +: COUNT_BITS];
    assign upd_cnt     = (&upd_cnt_old) ? upd_cnt_old : upd_cnt_old + COUNT_BITS'(1);
    assign target_eff  = (target_reg == '0) ? 16'd1 : target_reg;
    assign upd_retire  = 32'(upd_cnt) >= 32'(target_eff);
    assign upd_newly   = upd_retire && !word_reg[MARK_B];

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (iss_reg == LIM_W'(ENTRIES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == CMD_DRAW) ? ST_SUM : ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_IDLE;
            end
            ST_SUM: begin
                if (sum_done) begin
                    state_next = (sum_reg == '0) ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Handshake and table memory controls.
    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = iss_reg[IDX_W-1:0];
        ram_wdata = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_LOAD: begin
                // A load clears the served count and the retired mark.
                ram_we    = ld_ok_reg;
                ram_waddr = ld_addr_reg;
                ram_wdata = {1'b0, COUNT_BITS'(0), ld_w_reg};
            end
            ST_UPDATE: begin
                ram_we    = 1'b1;
                ram_waddr = pick_reg;
                ram_wdata = {word_reg[MARK_B] | upd_retire, upd_cnt,
                             upd_retire ? WEIGHT_BITS'(0) : word_reg[WEIGHT_BITS-1:0]};
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        iss_next      = iss_reg;
        rvalid_next   = 1'b0;
        ridx_next     = ridx_reg;
        sum_next      = sum_reg;
        nr_next       = nr_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        run_next      = run_reg;
        pick_next     = pick_reg;
        word_next     = word_reg;
        ld_ok_next    = ld_ok_reg;
        ld_addr_next  = ld_addr_reg;
        ld_w_next     = ld_w_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_CLEAR: begin
                iss_next = iss_reg + LIM_W'(1);
            end
            ST_IDLE: begin
                iss_next = '0;
                sum_next = '0;
                nr_next  = '0;
                if (accept) begin
                    quo_next     = s_tdata[46:15];
                    ld_ok_next   = 32'(s_tdata[6:0]) < 32'(ENTRIES);
                    ld_addr_next = IDX_W'(s_tdata[6:0]);
                    ld_w_next    = WEIGHT_BITS'(s_tdata[14:7]);
                end
            end
            ST_SUM: begin
                if (issue) begin
                    iss_next    = iss_reg + LIM_W'(1);
                    rvalid_next = 1'b1;
                    ridx_next   = iss_reg[IDX_W-1:0];
                end
                if (rvalid_reg) begin
                    sum_next = sum_reg + SUM_W'(rd_w);
                    nr_next  = nr_reg + LIM_W'(!rd_mark);
                end
                rem_next  = '0;
                dcnt_next = '0;
                if (sum_done && (sum_reg == '0)) begin
                    res_next             = '0;
                    res_next.all_retired = nr_reg == '0;
                end
            end
            ST_DIV: begin
                if (div_trial >= {1'b0, sum_reg}) begin
                    rem_next = SUM_W'(div_trial - {1'b0, sum_reg});
                end else begin
                    rem_next = SUM_W'(div_trial);
                end
                quo_next  = {quo_reg[30:0], 1'b0};
                dcnt_next = dcnt_reg + 5'd1;
                iss_next  = '0;
                run_next  = '0;
            end
            ST_SCAN: begin
                if (issue) begin
                    iss_next    = iss_reg + LIM_W'(1);
                    rvalid_next = 1'b1;
                    ridx_next   = iss_reg[IDX_W-1:0];
                end
                if (rvalid_reg) begin
                    run_next = run_new;
                end
                if (hit) begin
                    pick_next = ridx_reg;
                    word_next = ram_rdata;
                end
            end
            ST_UPDATE: begin
                res_next.found        = 1'b1;
                res_next.chosen_index = 7'(pick_reg);
                res_next.served_count = 16'(upd_cnt);
                res_next.just_retired = upd_retire;
                res_next.all_retired  = upd_newly ? (nr_reg == LIM_W'(1)) : (nr_reg == '0);
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                end
            end
            default: begin
                rvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            iss_reg      <= '0;
            rvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            target_reg   <= 16'd1;
            active_reg   <= ACT_W'(ENTRIES);
        end else begin
            state_reg    <= state_next;
            iss_reg      <= iss_next;
            rvalid_reg   <= rvalid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TARGET: target_reg <= cfg_data;
                    CFG_ACTIVE: active_reg <= ACT_W'(cfg_data[7:0]);
                    default:    target_reg <= target_reg;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        ridx_reg    <= ridx_next;
        sum_reg     <= sum_next;
        nr_reg      <= nr_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dcnt_reg    <= dcnt_next;
        run_reg     <= run_next;
        pick_reg    <= pick_next;
        word_reg    <= word_next;
        ld_ok_reg   <= ld_ok_next;
        ld_addr_reg <= ld_addr_next;
        ld_w_reg    <= ld_w_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {(OUT_TDATA_W - RES_W)'(0), m_tdata_reg};

endmodule

// ===== src/lws_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/lws_checker.sv =====
// ----------------------------------------------------------------------------
// Lottery weighted scheduler port checker
// Watches the ports of the top level over time; attached by a bind.
// ----------------------------------------------------------------------------
`include "lottery_weighted_scheduler_unit_defines.svh"

module lws_checker
    import lws_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result keeps its valid and its payload.
    `LWS_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

    // An empty draw carries no chosen entry, count or retirement.
    `LWS_ASSERT_NOW(a_empty_draw_clean, m_tvalid && !m_tdata[0], m_tdata[24:1] == '0, "empty draw carries entry data")

    // Only a chosen entry can retire.
    `LWS_ASSERT_NOW(a_retire_needs_found, m_tvalid && m_tdata[24], m_tdata[0], "retirement reported without a chosen entry")

    // The table is being cleared in the cycle after reset, so no request is taken.
    `LWS_ASSERT_NOW(a_busy_after_reset, !$past(aresetn), !s_tready, "request taken during the clearing pass")

endmodule

bind lottery_weighted_scheduler_unit lws_checker u_lws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_lottery_weighted_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Lottery weighted scheduler unit: testbench
// Drives load and draw requests into the scheduler and keeps its own copy of
// the weight table, served counts and retired marks. Every draw result is
// checked field by field against that copy. A directed part comes first.
// A randomised part follows, with bursty requests, a stalling receiver and
// several register settings.
// ----------------------------------------------------------------------------
module tb_lottery_weighted_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lws_pkg::*;

    localparam int TABLE_ENTRIES = 128;
    // Trailing wait at the end of the run, longer than a full draw over 128 entries.
    localparam int TAIL_CYCLES   = 400;
    // A load writes the table in the state after the one that takes it.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 800;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 1420;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = CMD_LOAD;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = CFG_TARGET;
    logic [15:0]            cfg_data  = '0;

    // Our own view of the scheduler state and its two registers.
    logic [7:0]  table_weight  [TABLE_ENTRIES];
    logic [15:0] table_served  [TABLE_ENTRIES];
    bit          table_retired [TABLE_ENTRIES];
    logic [15:0] target_setting = 16'd1;
    logic [7:0]  active_setting = 8'd128;

    // Draw results still owed by the block, oldest first.
    lws_result_t awaited_draws [$];

    int error_count = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int rx_mode     = 0;
    int rx_left     = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;

    lottery_weighted_scheduler_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Scheduler behaviour. A load stores the weight and clears the entry's
    // count and retired mark. A draw sums the active weights, reduces the
    // random word modulo that sum and walks the active entries until the
    // running sum passes the reduced value. The chosen entry's count rises by
    // one (saturating) and the entry retires once the count reaches the target.
    // ------------------------------------------------------------------------
    task automatic apply_request(input logic cmd, input logic [6:0] idx,
                                 input logic [7:0] w, input logic [31:0] rw);
        lws_result_t r;
        int unsigned n, total, draw, run, pick, k;
        logic [16:0] cnt;
        logic [15:0] tgt;
        if (cmd == CMD_LOAD) begin
            table_weight[idx]  = w;
            table_served[idx]  = '0;
            table_retired[idx] = 1'b0;
            return;
        end
        // An active count of zero acts as one, and anything above the table
        // size acts as the whole table.
        n = (active_setting == 8'd0) ? 1 :
            (active_setting > TABLE_ENTRIES) ? TABLE_ENTRIES : active_setting;
        r = '0;
        total = 0;
        for (k = 0; k < n; k++) total += table_weight[k];
        if (total != 0) begin
            draw = rw % total;
            run  = 0;
            pick = 0;
            for (k = 0; k < n; k++) begin
                run += table_weight[k];
                if (draw < run) begin
                    pick = k;
                    break;
                end
            end
            cnt = {1'b0, table_served[pick]};
            if (cnt < 17'h0FFFF) cnt++;
            table_served[pick] = cnt[15:0];
            // A target of zero behaves as a target of one. A lowered target
            // retires an entry already past it the next time it is chosen.
            tgt = (target_setting == 16'd0) ? 16'd1 : target_setting;
            if (cnt >= {1'b0, tgt}) begin
                r.just_retired      = 1'b1;
                table_weight[pick]  = '0;
                table_retired[pick] = 1'b1;
            end
            r.found        = 1'b1;
            r.chosen_index = 7'(pick);
            r.served_count = cnt[15:0];
        end
        // With nothing to draw the other fields stay zero, but the retired
        // state of the active entries is still reported.
        r.all_retired = 1'b1;
        for (k = 0; k < n; k++) if (!table_retired[k]) r.all_retired = 1'b0;
        awaited_draws.push_back(r);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
        lws_result_t got, want;
        got = lws_result_t'(word[RES_W-1:0]);
        if (awaited_draws.size() == 0) begin
            $error("draw result %h arrived with no draw outstanding", word);
            error_count++;
            return;
        end
        want = awaited_draws.pop_front();
        compare_field("found",        want.found,        got.found);
        compare_field("chosen_index", want.chosen_index, got.chosen_index);
        compare_field("served_count", want.served_count, got.served_count);
        compare_field("just_retired", want.just_retired, got.just_retired);
        compare_field("all_retired",  want.all_retired,  got.all_retired);
    endtask

    // ------------------------------------------------------------------------
    // Result side. Results are checked at the edge that takes them. The
    // ready line then follows a pattern of its own: stretches always ready,
    // stretches of coin tosses and stretches of mostly stalled, plus the long
    // hold-off that a test can ask for.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result(m_tdata);
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(20, 150);
            end
            rx_left--;
            case (rx_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 1) == 1);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 4) == 0);
                end
            endcase
        end
    end

    // Watchdog: the run ends if no channel moves anything for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[lottery_weighted_scheduler_unit] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side. Requests go out in bursts of random length with random
    // gaps between them; about a quarter of the bursts follow on with no gap.
    // The valid line stays high from one request to the next inside a burst.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic cmd, input logic [6:0] idx,
                                input logic [7:0] w, input logic [31:0] rw);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, rw, w, idx};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        apply_request(cmd, idx, w, rw);
    endtask

    // Stops the request side and waits until every draw has been answered,
    // then gives a trailing load time to finish.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        wait (awaited_draws.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Registers are only written while the block is idle.
    task automatic write_register(input logic idx, input logic [15:0] value);
        drain_and_settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TARGET) target_setting = value;
        else active_setting = value[7:0];
    endtask

    function automatic logic [7:0] random_weight();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2) return 8'd0;
        if (roll == 2) return 8'd255;
        return 8'($urandom_range(1, 254));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Straight after reset every weight is zero, so a draw finds nothing.
    task automatic test_empty_table();
        send_request(CMD_DRAW, 7'd0, 8'd0, 32'd0);
        send_request(CMD_DRAW, 7'd127, 8'd255, 32'hFFFF_FFFF);
    endtask

    // Extreme indexes, weights and random words over the full table. The
    // upper byte of the active-count write is not part of the register.
    task automatic test_field_extremes();
        write_register(CFG_ACTIVE, 16'hFF80);
        write_register(CFG_TARGET, 16'hFFFF);
        send_request(CMD_LOAD, 7'd0, 8'd255, 32'hFFFF_FFFF);
        send_request(CMD_LOAD, 7'd127, 8'd255, 32'd0);
        send_request(CMD_LOAD, 7'd64, 8'd1, 32'h5555_AAAA);
        send_request(CMD_DRAW, 7'd0, 8'd0, 32'd0);
        send_request(CMD_DRAW, 7'd0, 8'd0, 32'hFFFF_FFFF);
        send_request(CMD_DRAW, 7'd127, 8'd255, 32'd255);
        send_request(CMD_DRAW, 7'd127, 8'd255, 32'd256);
    endtask

    // An active count of zero leaves one entry in play; a weight loaded into
    // an inactive entry waits until a count above the table size brings it in.
    task automatic test_active_limits();
        write_register(CFG_ACTIVE, 16'd0);
        send_request(CMD_LOAD, 7'd0, 8'd0, 32'd0);
        send_request(CMD_LOAD, 7'd1, 8'd200, 32'd0);
        send_request(CMD_DRAW, 7'd0, 8'd0, 32'h1234_5678);
        write_register(CFG_ACTIVE, 16'd255);
        send_request(CMD_DRAW, 7'd0, 8'd0, 32'd300);
    endtask

    // A zero target retires on the first pick. Once both active entries have
    // retired, draws report that nothing was found and that all are retired.
    // Lowering the target below a count retires that entry on its next pick.
    task automatic test_retirement();
        write_register(CFG_TARGET, 16'd0);
        write_register(CFG_ACTIVE, 16'd2);
        send_request(CMD_LOAD, 7'd0, 8'd3, 32'd0);
        send_request(CMD_LOAD, 7'd1, 8'd9, 32'd0);
        send_request(CMD_DRAW, 7'd0, 8'd0, 32'd7);
        send_request(CMD_DRAW, 7'd0, 8'd0, 32'd7);
        send_request(CMD_DRAW, 7'd0, 8'd0, 32'd7);
        write_register(CFG_TARGET, 16'd10);
        write_register(CFG_ACTIVE, 16'd1);
        send_request(CMD_LOAD, 7'd0, 8'd5, 32'd0);
        repeat (3) send_request(CMD_DRAW, 7'd0, 8'd0, $urandom);
        write_register(CFG_TARGET, 16'd2);
        send_request(CMD_DRAW, 7'd0, 8'd0, $urandom);
        send_request(CMD_DRAW, 7'd0, 8'd0, $urandom);
    endtask

    // The receiver holds off for a long stretch while draws keep coming, so
    // the output register fills and the request side stalls. The request
    // side then pauses until every result is back.
    task automatic test_backpressure();
        int k;
        write_register(CFG_TARGET, 16'hFFFF);
        write_register(CFG_ACTIVE, 16'd4);
        for (k = 0; k < 4; k++) send_request(CMD_LOAD, 7'(k), 8'($urandom_range(1, 255)), $urandom);
        hold_req = 1'b1;
        repeat (12) send_request(CMD_DRAW, 7'($urandom), 8'($urandom), $urandom);
        drain_and_settle();
    endtask

    // Random phases: each picks register settings (mostly small tables and
    // low targets so that entries retire often), loads every active entry,
    // and then mixes draws with reloads, some of them outside the active set.
    task automatic test_random_phases();
        int done_items, phase_len, roll, n, k;
        logic [15:0] tgt;
        logic [7:0]  act;
        logic [6:0]  idx;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 9);
            if (roll < 7) act = 8'($urandom_range(1, 16));
            else if (roll < 9) act = 8'($urandom_range(17, 127));
            else act = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(128, 255));
            roll = $urandom_range(0, 9);
            if (roll < 6) tgt = 16'($urandom_range(1, 4));
            else if (roll < 9) tgt = 16'($urandom_range(5, 40));
            else begin
                case ($urandom_range(0, 2))
                    0: tgt = 16'd0;
                    1: tgt = 16'hFFFF;
                    default: tgt = 16'($urandom);
                endcase
            end
            if ($urandom_range(0, 3) != 0) write_register(CFG_TARGET, tgt);
            write_register(CFG_ACTIVE, {8'($urandom), act});
            n = (act == 8'd0) ? 1 : (act > TABLE_ENTRIES) ? TABLE_ENTRIES : act;

            for (k = 0; k < n; k++) send_request(CMD_LOAD, 7'(k), random_weight(), $urandom);
            phase_len = $urandom_range(10, 60);
            for (k = 0; k < phase_len; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    idx = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                      : 7'($urandom_range(0, n - 1));
                    send_request(CMD_LOAD, idx, random_weight(), $urandom);
                end else begin
                    send_request(CMD_DRAW, 7'($urandom), 8'($urandom), $urandom);
                end
            end
            done_items += n + phase_len;
        end
    endtask

    initial begin
        int k;
        for (k = 0; k < TABLE_ENTRIES; k++) begin
            table_weight[k]  = '0;
            table_served[k]  = '0;
            table_retired[k] = 1'b0;
        end
        // Reset is held once at the start; the block then clears its table
        // and only takes requests after that pass.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_field_extremes();
        test_active_limits();
        test_retirement();
        test_backpressure();
        test_random_phases();

        drain_and_settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[lottery_weighted_scheduler_unit] OK");
        end else begin
            $display("[lottery_weighted_scheduler_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/lws_pkg.sv
src/lws_ram.sv
src/lottery_weighted_scheduler_unit.sv
src/lws_checker.sv
tb/tb_lottery_weighted_scheduler_unit.sv
